/* sv/porc_pkg.sv */
// Shared types, constants and lane tables of the orientation rotation unit.
`default_nettype none
package porc_pkg;

   localparam int ELEM_WIDTH   = 24;
   localparam int ANGLE_WIDTH  = 17;
   localparam int RED_WIDTH    = ANGLE_WIDTH + 2;
   localparam int TRIG_WIDTH   = 18;
   localparam int XY_WIDTH     = 20;
   localparam int Z_WIDTH      = 26;
   localparam int M_WIDTH      = ELEM_WIDTH + 2;
   localparam int PROD_WIDTH   = M_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;
   localparam int FRAC_BITS    = 16;
   localparam int RND_WIDTH    = SUM_WIDTH - FRAC_BITS;
   localparam int NUM_ELEMS    = 9;
   localparam int NUM_MID      = 11;
   localparam int IDX_WIDTH    = 4;
   localparam int CORDIC_STEPS = 16;
   localparam int SC_LATENCY   = CORDIC_STEPS + 2;
   localparam int PIPE_DEPTH   = SC_LATENCY + 4;
   localparam int LATENCY      = PIPE_DEPTH + 1;

   localparam logic signed [RED_WIDTH-1:0] FULL_TURN    = RED_WIDTH'(92160);
   localparam logic signed [RED_WIDTH-1:0] HALF_TURN    = RED_WIDTH'(46080);
   localparam logic signed [RED_WIDTH-1:0] QUARTER_TURN = RED_WIDTH'(23040);
   localparam logic signed [XY_WIDTH-1:0]  CORDIC_X0    = XY_WIDTH'(39797);
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE    = TRIG_WIDTH'(65536);
   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF   = SUM_WIDTH'(32768);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [M_WIDTH-1:0]    mid_type;
   typedef logic signed [TRIG_WIDTH-1:0] coef_val_type;
   typedef logic [IDX_WIDTH-1:0]         idx_type;

   typedef struct packed {
      coef_val_type cos_v;
      coef_val_type sin_v;
   } trig_type;

   typedef enum logic [2:0] {
      COEF_ZERO,
      COEF_ONE,
      COEF_COS,
      COEF_SIN,
      COEF_NSIN
   } coef_type;

   typedef struct packed {
      idx_type  a_idx;
      coef_type ka;
      idx_type  b_idx;
      coef_type kb;
   } lane_cfg_type;

   function automatic logic signed [Z_WIDTH-1:0] atan_q16(input int step);
      logic signed [Z_WIDTH-1:0] v;
      case (step)
         0:  v = Z_WIDTH'(2949120);
         1:  v = Z_WIDTH'(1740967);
         2:  v = Z_WIDTH'(919879);
         3:  v = Z_WIDTH'(466945);
         4:  v = Z_WIDTH'(234379);
         5:  v = Z_WIDTH'(117266);
         6:  v = Z_WIDTH'(58666);
         7:  v = Z_WIDTH'(29335);
         8:  v = Z_WIDTH'(14668);
         9:  v = Z_WIDTH'(7334);
         10: v = Z_WIDTH'(3667);
         11: v = Z_WIDTH'(1833);
         12: v = Z_WIDTH'(917);
         13: v = Z_WIDTH'(458);
         14: v = Z_WIDTH'(229);
         15: v = Z_WIDTH'(115);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic coef_val_type coef_value(input coef_type sel, input trig_type t);
      coef_val_type v;
      case (sel)
         COEF_ONE:  v = TRIG_ONE;
         COEF_COS:  v = t.cos_v;
         COEF_SIN:  v = t.sin_v;
         COEF_NSIN: v = -t.sin_v;
         default:   v = '0;
      endcase
      return v;
   endfunction

   function automatic lane_cfg_type mk(input int a, input coef_type ka,
                                       input int b, input coef_type kb);
      lane_cfg_type c;
      c.a_idx = IDX_WIDTH'(a);
      c.ka    = ka;
      c.b_idx = IDX_WIDTH'(b);
      c.kb    = kb;
      return c;
   endfunction

   // first product: mode 0 is R(-phi)*S, mode 1 is U*T (row 0 passes through)
   function automatic lane_cfg_type first_cfg(input logic mode, input int lane);
      lane_cfg_type c;
      c = mk(0, COEF_ZERO, 0, COEF_ZERO);
      if (mode) begin
         case (lane)
            0: c = mk(0, COEF_ONE, 0, COEF_ZERO);
            1: c = mk(1, COEF_ONE, 0, COEF_ZERO);
            2: c = mk(2, COEF_ONE, 0, COEF_ZERO);
            3: c = mk(3, COEF_ONE, 0, COEF_ZERO);
            4: c = mk(4, COEF_ONE, 0, COEF_ZERO);
            5: c = mk(5, COEF_COS, 6, COEF_SIN);
            6: c = mk(6, COEF_COS, 8, COEF_SIN);
            7: c = mk(6, COEF_COS, 5, COEF_NSIN);
            8: c = mk(8, COEF_COS, 6, COEF_NSIN);
            9: c = mk(7, COEF_NSIN, 0, COEF_ZERO);
            10: c = mk(7, COEF_COS, 0, COEF_ZERO);
            default: c = mk(0, COEF_ZERO, 0, COEF_ZERO);
         endcase
      end else begin
         case (lane)
            0: c = mk(0, COEF_COS, 4, COEF_SIN);
            1: c = mk(1, COEF_COS, 5, COEF_SIN);
            2: c = mk(2, COEF_COS, 6, COEF_SIN);
            3: c = mk(3, COEF_COS, 7, COEF_SIN);
            4: c = mk(4, COEF_COS, 0, COEF_NSIN);
            5: c = mk(5, COEF_COS, 1, COEF_NSIN);
            6: c = mk(6, COEF_COS, 2, COEF_NSIN);
            7: c = mk(7, COEF_COS, 3, COEF_NSIN);
            default: c = mk(0, COEF_ZERO, 0, COEF_ZERO);
         endcase
      end
      return c;
   endfunction

   // second product on the intermediate lanes
   function automatic lane_cfg_type second_cfg(input logic mode, input int lane);
      lane_cfg_type c;
      c = mk(0, COEF_ZERO, 0, COEF_ZERO);
      if (mode) begin
         case (lane)
            0: c = mk(0, COEF_ONE, 0, COEF_ZERO);
            1: c = mk(1, COEF_COS, 3, COEF_SIN);
            2: c = mk(2, COEF_COS, 4, COEF_SIN);
            3: c = mk(3, COEF_COS, 1, COEF_NSIN);
            4: c = mk(4, COEF_COS, 2, COEF_NSIN);
            5: c = mk(5, COEF_COS, 6, COEF_SIN);
            6: c = mk(6, COEF_COS, 5, COEF_NSIN);
            7: c = mk(10, COEF_COS, 9, COEF_NSIN);
            8: c = mk(8, COEF_COS, 7, COEF_NSIN);
            default: c = mk(0, COEF_ZERO, 0, COEF_ZERO);
         endcase
      end else begin
         case (lane)
            0: c = mk(0, COEF_COS, 2, COEF_SIN);
            1: c = mk(1, COEF_COS, 3, COEF_SIN);
            2: c = mk(2, COEF_COS, 0, COEF_NSIN);
            3: c = mk(3, COEF_COS, 1, COEF_NSIN);
            4: c = mk(4, COEF_COS, 6, COEF_SIN);
            5: c = mk(5, COEF_COS, 7, COEF_SIN);
            6: c = mk(6, COEF_COS, 4, COEF_NSIN);
            7: c = mk(7, COEF_COS, 5, COEF_NSIN);
            default: c = mk(0, COEF_ZERO, 0, COEF_ZERO);
         endcase
      end
      return c;
   endfunction

   function automatic elem_type sat_elem(input logic signed [RND_WIDTH-1:0] v);
      elem_type r;
      if ((&v[RND_WIDTH-1:ELEM_WIDTH-1]) || !(|v[RND_WIDTH-1:ELEM_WIDTH-1])) begin
         r = v[ELEM_WIDTH-1:0];
      end else if (v[RND_WIDTH-1]) begin
         r = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/porc_sincos.sv */
// Pipelined degree-domain CORDIC: angle reduction, 16 rotation stages, sign and clamp.
`default_nettype none
module porc_sincos (
   input  wire logic                                   clock,
   input  wire logic signed [porc_pkg::ANGLE_WIDTH-1:0] angle,
   input  wire logic                                   dbl,
   output porc_pkg::trig_type                          trig
);
   localparam int N = porc_pkg::CORDIC_STEPS;

   logic signed [porc_pkg::RED_WIDTH-1:0] a_w;
   logic signed [porc_pkg::RED_WIDTH-1:0] a_red;
   logic signed [porc_pkg::RED_WIDTH-1:0] a_fold;
   logic                                  neg_in;

   logic signed [porc_pkg::XY_WIDTH-1:0] x_ff [N+1];
   logic signed [porc_pkg::XY_WIDTH-1:0] y_ff [N+1];
   logic signed [porc_pkg::Z_WIDTH-1:0]  z_ff [N+1];
   logic                                 neg_ff [N+1];

   logic signed [porc_pkg::XY_WIDTH-1:0] xf;
   logic signed [porc_pkg::XY_WIDTH-1:0] yf;
   porc_pkg::trig_type                   trig_in;
   porc_pkg::trig_type                   trig_ff;

   // reduce into [-180,180) then fold into [-90,90]
   always_comb begin
      a_w = dbl ? (porc_pkg::RED_WIDTH'(angle) <<< 1) : porc_pkg::RED_WIDTH'(angle);
      if (a_w >= porc_pkg::HALF_TURN) begin
         a_red = a_w - porc_pkg::FULL_TURN;
      end else if (a_w < -porc_pkg::HALF_TURN) begin
         a_red = a_w + porc_pkg::FULL_TURN;
      end else begin
         a_red = a_w;
      end
      neg_in = 1'b0;
      a_fold = a_red;
      if (a_red > porc_pkg::QUARTER_TURN) begin
         a_fold = a_red - porc_pkg::HALF_TURN;
         neg_in = 1'b1;
      end else if (a_red < -porc_pkg::QUARTER_TURN) begin
         a_fold = a_red + porc_pkg::HALF_TURN;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= porc_pkg::CORDIC_X0;
      y_ff[0]   <= '0;
      z_ff[0]   <= porc_pkg::Z_WIDTH'(a_fold) <<< 8;
      neg_ff[0] <= neg_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (!z_ff[i][porc_pkg::Z_WIDTH-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - porc_pkg::atan_q16(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + porc_pkg::atan_q16(i);
         end
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   always_comb begin
      xf = neg_ff[N] ? -x_ff[N] : x_ff[N];
      yf = neg_ff[N] ? -y_ff[N] : y_ff[N];
      if (xf > porc_pkg::XY_WIDTH'(porc_pkg::TRIG_ONE)) begin
         trig_in.cos_v = porc_pkg::TRIG_ONE;
      end else if (xf < -porc_pkg::XY_WIDTH'(porc_pkg::TRIG_ONE)) begin
         trig_in.cos_v = -porc_pkg::TRIG_ONE;
      end else begin
         trig_in.cos_v = xf[porc_pkg::TRIG_WIDTH-1:0];
      end
      if (yf > porc_pkg::XY_WIDTH'(porc_pkg::TRIG_ONE)) begin
         trig_in.sin_v = porc_pkg::TRIG_ONE;
      end else if (yf < -porc_pkg::XY_WIDTH'(porc_pkg::TRIG_ONE)) begin
         trig_in.sin_v = -porc_pkg::TRIG_ONE;
      end else begin
         trig_in.sin_v = yf[porc_pkg::TRIG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
   end

   assign trig = trig_ff;
endmodule
`default_nettype wire

/* sv/porc_lane.sv */
// Two-term multiply-accumulate lane: a*ka + b*kb, rounded half up by 2^16.
`default_nettype none
module porc_lane (
   input  wire logic                                  clock,
   input  wire logic signed [porc_pkg::M_WIDTH-1:0]    a,
   input  wire logic signed [porc_pkg::TRIG_WIDTH-1:0] ka,
   input  wire logic signed [porc_pkg::M_WIDTH-1:0]    b,
   input  wire logic signed [porc_pkg::TRIG_WIDTH-1:0] kb,
   output logic signed [porc_pkg::RND_WIDTH-1:0]      sum
);
   logic signed [porc_pkg::PROD_WIDTH-1:0] pa_ff;
   logic signed [porc_pkg::PROD_WIDTH-1:0] pb_ff;
   logic signed [porc_pkg::SUM_WIDTH-1:0]  acc;
   logic signed [porc_pkg::RND_WIDTH-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      pa_ff <= porc_pkg::PROD_WIDTH'(a) * porc_pkg::PROD_WIDTH'(ka);
      pb_ff <= porc_pkg::PROD_WIDTH'(b) * porc_pkg::PROD_WIDTH'(kb);
   end

   assign acc = porc_pkg::SUM_WIDTH'(pa_ff) + porc_pkg::SUM_WIDTH'(pb_ff)
              + porc_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      sum_ff <= acc[porc_pkg::SUM_WIDTH-1:porc_pkg::FRAC_BITS];
   end

   assign sum = sum_ff;
endmodule
`default_nettype wire

/* sv/polarimetric_orientation_rotation_unit.sv */
// Top level of the polarimetric orientation-angle rotation pipeline.
//
// Usage:
//  - Request: pulse start with req_pixel_valid, req_angle_deg (Q8.8 degrees)
//    and req_elem_0..8 (Q8.15). An item is taken on any edge with start high
//    and busy low; busy is low in every cycle except during and right after reset.
//  - Response: rsp_strobe is high for one cycle with rsp_res_0..8. The
//    receiver cannot hold results off; rsp_res_* read zero between results.
//  - Config: csr_matrix_mode picks 2x2 scattering (0) or 3x3 coherency (1),
//    written when csr_valid is high (csr_ready is low only during reset).
//    Change it only with no item in flight.
//  - Items are taken at one item per cycle while busy is low. Each item
//    passes through the 18-stage CORDIC (reduction, 16 rotations,
//    sign/clamp), two multiply-round passes that each register the products
//    and then the rounded sum, and the saturating output register.
//  - Invalid pixels travel the pipe and come out as all zeros; res_8 is
//    zero in scattering mode.
//  - Reset (synchronous) clears the valid pipe and sets mode to scattering.
`default_nettype none
module polarimetric_orientation_rotation_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic                                    req_pixel_valid,
   input  wire logic signed [porc_pkg::ANGLE_WIDTH-1:0] req_angle_deg,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_0,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_1,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_2,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_3,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_4,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_5,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_6,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_7,
   input  wire logic signed [porc_pkg::ELEM_WIDTH-1:0]  req_elem_8,
   output logic                                         rsp_strobe,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_0,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_1,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_2,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_3,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_4,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_5,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_6,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_7,
   output logic signed [porc_pkg::ELEM_WIDTH-1:0]       rsp_res_8,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic                                    csr_matrix_mode
);
   localparam int NE = porc_pkg::NUM_ELEMS;
   localparam int NM = porc_pkg::NUM_MID;
   localparam int SL = porc_pkg::SC_LATENCY;
   localparam int PD = porc_pkg::PIPE_DEPTH;
   localparam int EW = porc_pkg::ELEM_WIDTH;
   localparam int MW = porc_pkg::M_WIDTH;

   logic busy_ff;
   logic mode_ff;
   logic accept;

   // item valid and pixel valid ride alongside the data
   logic vld_ff [PD];
   logic pix_ff [PD];

   porc_pkg::elem_type req_elem [NE];
   porc_pkg::elem_type elem_ff  [SL][NE];

   porc_pkg::trig_type trig;
   porc_pkg::trig_type trig1_ff;
   porc_pkg::trig_type trig2_ff;

   logic signed [porc_pkg::RND_WIDTH-1:0] mid_sum [NM];
   porc_pkg::mid_type                     mid     [NM];
   logic signed [porc_pkg::RND_WIDTH-1:0] out_sum [NE];
   porc_pkg::elem_type                    res_ff  [NE];
   porc_pkg::elem_type                    res_in  [NE];
   logic                                  strobe_ff;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !reset;

   assign req_elem[0] = req_elem_0;
   assign req_elem[1] = req_elem_1;
   assign req_elem[2] = req_elem_2;
   assign req_elem[3] = req_elem_3;
   assign req_elem[4] = req_elem_4;
   assign req_elem[5] = req_elem_5;
   assign req_elem[6] = req_elem_6;
   assign req_elem[7] = req_elem_7;
   assign req_elem[8] = req_elem_8;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         mode_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_matrix_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PD; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < PD; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // payload delay lines: no reset
   always_ff @(posedge clock) begin
      pix_ff[0] <= req_pixel_valid;
      for (int k = 1; k < PD; k++) begin
         pix_ff[k] <= pix_ff[k-1];
      end
      elem_ff[0] <= req_elem;
      for (int k = 1; k < SL; k++) begin
         elem_ff[k] <= elem_ff[k-1];
      end
      trig1_ff <= trig;
      trig2_ff <= trig1_ff;
   end

   // coherency mode rotates by twice the angle
   porc_sincos u_sincos (
      .clock (clock),
      .angle (req_angle_deg),
      .dbl   (mode_ff),
      .trig  (trig)
   );

   // first product pass on the delayed input elements
   for (genvar l = 0; l < NM; l++) begin : g_first
      porc_pkg::lane_cfg_type cfg;
      assign cfg = porc_pkg::first_cfg(mode_ff, l);
      porc_lane u_lane (
         .clock (clock),
         .a     (MW'(elem_ff[SL-1][cfg.a_idx])),
         .ka    (porc_pkg::coef_value(cfg.ka, trig)),
         .b     (MW'(elem_ff[SL-1][cfg.b_idx])),
         .kb    (porc_pkg::coef_value(cfg.kb, trig)),
         .sum   (mid_sum[l])
      );
      assign mid[l] = mid_sum[l][MW-1:0];
   end

   // second product pass on the intermediate matrix
   for (genvar l = 0; l < NE; l++) begin : g_second
      porc_pkg::lane_cfg_type cfg;
      assign cfg = porc_pkg::second_cfg(mode_ff, l);
      porc_lane u_lane (
         .clock (clock),
         .a     (mid[cfg.a_idx]),
         .ka    (porc_pkg::coef_value(cfg.ka, trig2_ff)),
         .b     (mid[cfg.b_idx]),
         .kb    (porc_pkg::coef_value(cfg.kb, trig2_ff)),
         .sum   (out_sum[l])
      );
      assign res_in[l] = (vld_ff[PD-1] && pix_ff[PD-1])
                       ? porc_pkg::sat_elem(out_sum[l]) : EW'(0);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[PD-1];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_res_0  = res_ff[0];
   assign rsp_res_1  = res_ff[1];
   assign rsp_res_2  = res_ff[2];
   assign rsp_res_3  = res_ff[3];
   assign rsp_res_4  = res_ff[4];
   assign rsp_res_5  = res_ff[5];
   assign rsp_res_6  = res_ff[6];
   assign rsp_res_7  = res_ff[7];
   assign rsp_res_8  = res_ff[8];
endmodule
`default_nettype wire

/* sv/porc_checker.sv */
// Port-level checks of the rotation unit and their bind.
`default_nettype none
module porc_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   start,
   input wire logic                                   busy,
   input wire logic                                   req_pixel_valid,
   input wire logic                                   rsp_strobe,
   input wire logic signed [porc_pkg::ELEM_WIDTH-1:0] rsp_res_0,
   input wire logic signed [porc_pkg::ELEM_WIDTH-1:0] rsp_res_4,
   input wire logic signed [porc_pkg::ELEM_WIDTH-1:0] rsp_res_8
);
   a_item_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(porc_pkg::LATENCY) rsp_strobe)
      else $error("accepted item gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, porc_pkg::LATENCY))
      else $error("result without an item");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_pixel_valid) |-> ##(porc_pkg::LATENCY)
      (rsp_res_0 == '0 && rsp_res_4 == '0 && rsp_res_8 == '0))
      else $error("invalid pixel gave nonzero result");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> (rsp_res_0 == '0 && rsp_res_4 == '0 && rsp_res_8 == '0))
      else $error("result bus not zero between items");
endmodule

bind polarimetric_orientation_rotation_unit porc_checker u_porc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_pixel_valid (req_pixel_valid),
   .rsp_strobe      (rsp_strobe),
   .rsp_res_0       (rsp_res_0),
   .rsp_res_4       (rsp_res_4),
   .rsp_res_8       (rsp_res_8)
);
`default_nettype wire
